// ----- src/fvn_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fvn_pkg: shared types and constants for fractal value noise
// Widths, register codes, controller states, datapath operations, the
// permutation table and the reciprocal table for the final normalization.
// ----------------------------------------------------------------------------
package fvn_pkg;

    localparam int MAX_OCTAVES = 8;
    localparam int FRAC_BITS   = 16;
    localparam int LAT_BITS    = 8;

    localparam int COORD_W     = 32;
    localparam int FREQ_W      = 24;
    localparam int OCT_W       = 4;
    localparam int SEED_W      = 8;
    localparam int OFFSET_W    = 32;
    localparam int OUT_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int POS_W       = FRAC_BITS + LAT_BITS;
    localparam int ACC_W       = POS_W + MAX_OCTAVES;
    localparam int OCT_CNT_W   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int DIVIDEND_W  = ACC_W - (FRAC_BITS - LAT_BITS);
    localparam int RECIP_W     = 32;
    localparam int REM_W       = DIVIDEND_W + MAX_OCTAVES + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQUENCY = 3'd0,
        CFG_OCTAVES   = 3'd1,
        CFG_SEED      = 3'd2,
        CFG_OFFSET_X  = 3'd3,
        CFG_OFFSET_Y  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic [OCT_W-1:0]  octaves;
        logic [SEED_W-1:0] seed;
        logic [POS_W-1:0]  offset_x;
        logic [POS_W-1:0]  offset_y;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE_MUL,
        ST_SCALE_ADD,
        ST_SQUARE,
        ST_WEIGHT,
        ST_BLEND_X,
        ST_BLEND_Y,
        ST_ACCUM,
        ST_DIV_MUL,
        ST_DIV_FIX
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCALE_MUL,
        OP_SCALE_ADD,
        OP_SQUARE,
        OP_WEIGHT,
        OP_BLEND_X,
        OP_BLEND_Y,
        OP_ACCUM,
        OP_DIV_MUL,
        OP_DIV_FIX
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    // floor((2^32-1)/(2^n-1)) for n = 1..MAX_OCTAVES
    localparam logic [RECIP_W-1:0] RECIP_TAB [MAX_OCTAVES] = '{
        32'hFFFF_FFFF / 32'd1,
        32'hFFFF_FFFF / 32'd3,
        32'hFFFF_FFFF / 32'd7,
        32'hFFFF_FFFF / 32'd15,
        32'hFFFF_FFFF / 32'd31,
        32'hFFFF_FFFF / 32'd63,
        32'hFFFF_FFFF / 32'd127,
        32'hFFFF_FFFF / 32'd255
    };

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    function automatic logic [7:0] perm(input logic [7:0] idx);
        return PERM_ROM[idx];
    endfunction

endpackage
`default_nettype wire

// ----- src/fractal_value_noise_2d.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fractal_value_noise_2d: fractal value noise over a 2D fixed-point plane
// Scales and offsets a Q16.16 coordinate, sums up to eight octaves of
// smoothstep-blended lattice values and returns a normalized Q0.16 word.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   input   | in        | i_valid / o_stall      | i_coord_x, i_coord_y
//   output  | out       | o_valid / i_stall      | o_noise_value
//   config  | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// An item holds the datapath from its accept until its result is loaded:
// scaling, four sequencer steps per octave through the blend datapath, a
// final accumulate and a two-step normalize.
// Synchronous active-low reset clears the sequencer, the output flag and
// the config registers to their reset values. A stalled result waits in the
// output register while the next word is taken and worked on.
// ----------------------------------------------------------------------------
module fractal_value_noise_2d import fvn_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic signed [COORD_W-1:0] i_coord_x,
    input  wire logic signed [COORD_W-1:0] i_coord_y,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [OUT_W-1:0]               o_noise_value,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_dp_cmd cmd;

    fvn_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    fvn_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_stall   (i_stall),
        .i_octaves (cfg.octaves),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_cmd     (cmd)
    );

    fvn_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .o_noise_value (o_noise_value)
    );

endmodule
`default_nettype wire

// ----- src/fvn_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fvn_cfg: configuration register file
// Takes register writes by index; the octave count is clamped on write to
// 1..MAX_OCTAVES, offsets keep only the bits that reach the lattice.
// ----------------------------------------------------------------------------
module fvn_cfg import fvn_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready,
    output t_cfg                       o_cfg
);

    t_cfg             r_cfg;
    t_cfg             n_cfg;
    logic [OCT_W-1:0] oct_raw;
    logic [OCT_W-1:0] oct_clamped;

    assign oct_raw = i_cfg_data[OCT_W-1:0];

    always_comb begin
        priority if (oct_raw == '0) begin
            oct_clamped = OCT_W'(1);
        end else if (oct_raw > OCT_W'(MAX_OCTAVES)) begin
            oct_clamped = OCT_W'(MAX_OCTAVES);
        end else begin
            oct_clamped = oct_raw;
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FREQUENCY: n_cfg.frequency = i_cfg_data[FREQ_W-1:0];
                CFG_OCTAVES:   n_cfg.octaves   = oct_clamped;
                CFG_SEED:      n_cfg.seed      = i_cfg_data[SEED_W-1:0];
                CFG_OFFSET_X:  n_cfg.offset_x  = i_cfg_data[POS_W-1:0];
                CFG_OFFSET_Y:  n_cfg.offset_y  = i_cfg_data[POS_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frequency <= FREQ_W'(1 << FRAC_BITS);
            r_cfg.octaves   <= OCT_W'(1);
            r_cfg.seed      <= '0;
            r_cfg.offset_x  <= '0;
            r_cfg.offset_y  <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule
`default_nettype wire

// ----- src/fvn_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fvn_ctrl: sequencer for the noise datapath
// Steps scale, four steps per octave, accumulate and normalize; owns the
// input stall and the output valid flag.
// ----------------------------------------------------------------------------
module fvn_ctrl import fvn_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_stall,
    input  wire logic [OCT_W-1:0] i_octaves,
    output logic                  o_stall,
    output logic                  o_valid,
    output t_dp_cmd               o_cmd
);

    t_state               r_state;
    t_state               n_state;
    logic [OCT_CNT_W-1:0] r_oct;
    logic [OCT_CNT_W-1:0] n_oct;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 last_octave;
    logic                 out_free;

    assign last_octave = (OCT_W'(r_oct) == (i_octaves - OCT_W'(1)));
    assign out_free    = !r_out_valid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        n_oct   = r_oct;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_SCALE_MUL;
            end
            ST_SCALE_MUL: n_state = ST_SCALE_ADD;
            ST_SCALE_ADD: begin
                n_state = ST_SQUARE;
                n_oct   = '0;
            end
            ST_SQUARE:  n_state = ST_WEIGHT;
            ST_WEIGHT:  n_state = ST_BLEND_X;
            ST_BLEND_X: n_state = ST_BLEND_Y;
            ST_BLEND_Y: begin
                if (last_octave) begin
                    n_state = ST_ACCUM;
                end else begin
                    n_state = ST_SQUARE;
                    n_oct   = r_oct + OCT_CNT_W'(1);
                end
            end
            ST_ACCUM:   n_state = ST_DIV_MUL;
            ST_DIV_MUL: n_state = ST_DIV_FIX;
            ST_DIV_FIX: begin
                // hold until the output register frees up
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_IDLE:      o_cmd.op = i_valid ? OP_LOAD : OP_NONE;
            ST_SCALE_MUL: o_cmd.op = OP_SCALE_MUL;
            ST_SCALE_ADD: o_cmd.op = OP_SCALE_ADD;
            ST_SQUARE:    o_cmd.op = OP_SQUARE;
            ST_WEIGHT:    o_cmd.op = OP_WEIGHT;
            ST_BLEND_X:   o_cmd.op = OP_BLEND_X;
            ST_BLEND_Y:   o_cmd.op = OP_BLEND_Y;
            ST_ACCUM:     o_cmd.op = OP_ACCUM;
            ST_DIV_MUL:   o_cmd.op = OP_DIV_MUL;
            ST_DIV_FIX: begin
                o_cmd.op       = OP_DIV_FIX;
                o_cmd.out_load = out_free;
            end
            default:      o_cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) n_out_valid = 1'b0;
        if (o_cmd.out_load)          n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_oct       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oct       <= n_oct;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

// ----- src/fvn_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fvn_dp: noise datapath
// Coordinate scaling, smoothstep weights, corner lookups, bilinear blend,
// octave accumulation and the reciprocal-multiply normalization.
// ----------------------------------------------------------------------------
module fvn_dp import fvn_pkg::*; (
    input  wire logic                      i_clk,
    input  wire t_dp_cmd                   i_cmd,
    input  wire t_cfg                      i_cfg,
    input  wire logic signed [COORD_W-1:0] i_coord_x,
    input  wire logic signed [COORD_W-1:0] i_coord_y,
    output logic [OUT_W-1:0]               o_noise_value
);

    localparam int PROD_W  = COORD_W + FREQ_W + 1;
    localparam int SQ_W    = 2 * FRAC_BITS;
    localparam int K_W     = FRAC_BITS + 2;
    localparam int WP_W    = FRAC_BITS + K_W;
    localparam int ONE_W   = FRAC_BITS + 1;
    localparam int BX_W    = POS_W + 1;
    localparam int BY_W    = POS_W + ONE_W;
    localparam int DIVP_W  = DIVIDEND_W + RECIP_W;
    localparam int DIVSR_W = MAX_OCTAVES + 1;

    localparam logic [K_W-1:0]   THREE_ONE = K_W'(3) << FRAC_BITS;
    localparam logic [ONE_W-1:0] ONE       = ONE_W'(1) << FRAC_BITS;

    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic [POS_W-1:0]          r_mx, r_my;
    logic [POS_W-1:0]          r_px, r_py;
    logic [FRAC_BITS-1:0]      r_s2x, r_s2y;
    logic [7:0]                r_pr0, r_pr1;
    logic [FRAC_BITS-1:0]      r_wx, r_wy;
    logic [7:0]                r_c00, r_c10, r_c01, r_c11;
    logic [POS_W-1:0]          r_lo, r_hi;
    logic [POS_W-1:0]          r_v;
    logic [ACC_W-1:0]          r_acc;
    logic [DIVIDEND_W-1:0]     r_qe;
    logic [OUT_W-1:0]          r_out;

    logic signed [PROD_W-1:0]  prod_x, prod_y;
    logic [LAT_BITS-1:0]       xi, yi;
    logic [FRAC_BITS-1:0]      sx, sy;
    logic [SQ_W-1:0]           sq_x, sq_y;
    logic [K_W-1:0]            k_x, k_y;
    logic [WP_W-1:0]           wp_x, wp_y;
    logic [ONE_W-1:0]          inv_wx, inv_wy;
    logic [BX_W-1:0]           lo_sum, hi_sum;
    logic [BY_W-1:0]           v_sum;
    logic [ACC_W-1:0]          acc_next;
    logic [DIVIDEND_W-1:0]     dividend;
    logic [OCT_CNT_W-1:0]      n_idx;
    logic [DIVP_W-1:0]         div_prod;
    logic [DIVSR_W-1:0]        divisor;
    logic [REM_W-1:0]          rem;
    logic [DIVIDEND_W-1:0]     quot;

    assign prod_x = r_cx * $signed({1'b0, i_cfg.frequency});
    assign prod_y = r_cy * $signed({1'b0, i_cfg.frequency});

    assign xi = r_px[POS_W-1:FRAC_BITS];
    assign yi = r_py[POS_W-1:FRAC_BITS];
    assign sx = r_px[FRAC_BITS-1:0];
    assign sy = r_py[FRAC_BITS-1:0];

    assign sq_x = SQ_W'(sx) * SQ_W'(sx);
    assign sq_y = SQ_W'(sy) * SQ_W'(sy);

    // smoothstep second factor: 3 - 2s
    assign k_x  = THREE_ONE - {1'b0, sx, 1'b0};
    assign k_y  = THREE_ONE - {1'b0, sy, 1'b0};
    assign wp_x = WP_W'(r_s2x) * WP_W'(k_x);
    assign wp_y = WP_W'(r_s2y) * WP_W'(k_y);

    assign inv_wx = ONE - ONE_W'(r_wx);
    assign inv_wy = ONE - ONE_W'(r_wy);

    assign lo_sum = BX_W'(r_c00) * BX_W'(inv_wx) + BX_W'(r_c10) * BX_W'(r_wx);
    assign hi_sum = BX_W'(r_c01) * BX_W'(inv_wx) + BX_W'(r_c11) * BX_W'(r_wx);
    assign v_sum  = BY_W'(r_lo) * BY_W'(inv_wy) + BY_W'(r_hi) * BY_W'(r_wy);

    // Horner form: each step doubles the weight of everything before
    assign acc_next = {r_acc[ACC_W-2:0], 1'b0} + ACC_W'(r_v);

    assign dividend = r_acc[ACC_W-1:FRAC_BITS-LAT_BITS];
    assign n_idx    = OCT_CNT_W'(i_cfg.octaves - OCT_W'(1));
    assign div_prod = DIVP_W'(dividend) * DIVP_W'(RECIP_TAB[n_idx]);

    // estimate is low by at most one: fix with one compare
    assign divisor = (DIVSR_W'(1) << i_cfg.octaves) - DIVSR_W'(1);
    assign rem     = REM_W'(dividend) - (REM_W'(r_qe) << i_cfg.octaves) + REM_W'(r_qe);
    assign quot    = (rem >= REM_W'(divisor)) ? r_qe + DIVIDEND_W'(1) : r_qe;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_NONE: begin
            end
            OP_LOAD: begin
                r_cx <= i_coord_x;
                r_cy <= i_coord_y;
            end
            OP_SCALE_MUL: begin
                r_mx <= prod_x[POS_W+FRAC_BITS-1:FRAC_BITS];
                r_my <= prod_y[POS_W+FRAC_BITS-1:FRAC_BITS];
            end
            OP_SCALE_ADD: begin
                r_px  <= r_mx + i_cfg.offset_x;
                r_py  <= r_my + i_cfg.offset_y;
                r_v   <= '0;
                r_acc <= '0;
            end
            OP_SQUARE: begin
                r_s2x <= sq_x[SQ_W-1:FRAC_BITS];
                r_s2y <= sq_y[SQ_W-1:FRAC_BITS];
                r_pr0 <= perm(yi + i_cfg.seed);
                r_pr1 <= perm(yi + 8'd1 + i_cfg.seed);
                r_acc <= acc_next;
            end
            OP_WEIGHT: begin
                r_wx  <= wp_x[SQ_W-1:FRAC_BITS];
                r_wy  <= wp_y[SQ_W-1:FRAC_BITS];
                r_c00 <= perm(r_pr0 + xi);
                r_c10 <= perm(r_pr0 + xi + 8'd1);
                r_c01 <= perm(r_pr1 + xi);
                r_c11 <= perm(r_pr1 + xi + 8'd1);
                // advance to the next octave's lattice
                r_px  <= {r_px[POS_W-2:0], 1'b0};
                r_py  <= {r_py[POS_W-2:0], 1'b0};
            end
            OP_BLEND_X: begin
                r_lo <= lo_sum[POS_W-1:0];
                r_hi <= hi_sum[POS_W-1:0];
            end
            OP_BLEND_Y: begin
                r_v <= v_sum[POS_W+FRAC_BITS-1:FRAC_BITS];
            end
            OP_ACCUM: begin
                r_acc <= acc_next;
            end
            OP_DIV_MUL: begin
                r_qe <= div_prod[DIVP_W-1:RECIP_W];
            end
            OP_DIV_FIX: begin
                if (i_cmd.out_load) r_out <= quot[OUT_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_noise_value = r_out;

endmodule
`default_nettype wire
